// File: design/egpa_pkg.sv
// ----------------------------------------------------------------------------
// egpa_pkg: shared types and constants
// Coefficient bundle, register map and pipeline latencies of the elliptical
// Gaussian pixel accumulator.
// ----------------------------------------------------------------------------
package egpa_pkg;

  // Width of the pixel index fields.
  localparam int IDX_W = 10;

  // Clamped magnitude width: |u| and |v| must stay below 8.0 in Q15.16.
  localparam int MAG_W = 19;

  // Width of one squared magnitude.
  localparam int SQ_W = 2 * MAG_W;

  // Width of the interpolated exp value in Q30 (at most 1.0).
  localparam int G_W = 31;

  // Register stages inside the coordinate and the exp units.
  localparam int COORD_LAT = 4;
  localparam int EXP_LAT   = 4;

  // Register map, word index within the configuration space.
  typedef enum logic [2:0] {
    REG_AMPLITUDE  = 3'd0,
    REG_U_COL_STEP = 3'd1,
    REG_U_ROW_STEP = 3'd2,
    REG_U_ORIGIN   = 3'd3,
    REG_V_COL_STEP = 3'd4,
    REG_V_ROW_STEP = 3'd5,
    REG_V_ORIGIN   = 3'd6
  } cfg_reg_t;

  // Coefficients of the two affine coordinate maps.
  typedef struct packed {
    logic signed [31:0] u_col_step;
    logic signed [31:0] u_row_step;
    logic signed [31:0] u_origin;
    logic signed [31:0] v_col_step;
    logic signed [31:0] v_row_step;
    logic signed [31:0] v_origin;
  } coef_t;

endpackage

// File: design/egpa_cfg_regs.sv
// ----------------------------------------------------------------------------
// egpa_cfg_regs: configuration register file
// Holds the amplitude and the six affine coefficients behind an APB-style
// port with zero wait states.
// ----------------------------------------------------------------------------
module egpa_cfg_regs
  import egpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic signed [31:0] amplitude,
  output coef_t              coef
);

  logic signed [31:0] amplitude_r;
  coef_t              coef_r;
  logic               wr_en;
  cfg_reg_t           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = cfg_reg_t'(paddr[4:2]);

  // Register writes; words beyond the map are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= '0;
      coef_r      <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_AMPLITUDE:  amplitude_r       <= pwdata;
        REG_U_COL_STEP: coef_r.u_col_step <= pwdata;
        REG_U_ROW_STEP: coef_r.u_row_step <= pwdata;
        REG_U_ORIGIN:   coef_r.u_origin   <= pwdata;
        REG_V_COL_STEP: coef_r.v_col_step <= pwdata;
        REG_V_ROW_STEP: coef_r.v_row_step <= pwdata;
        REG_V_ORIGIN:   coef_r.v_origin   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_sel)
      REG_AMPLITUDE:  prdata = amplitude_r;
      REG_U_COL_STEP: prdata = coef_r.u_col_step;
      REG_U_ROW_STEP: prdata = coef_r.u_row_step;
      REG_U_ORIGIN:   prdata = coef_r.u_origin;
      REG_V_COL_STEP: prdata = coef_r.v_col_step;
      REG_V_ROW_STEP: prdata = coef_r.v_row_step;
      REG_V_ORIGIN:   prdata = coef_r.v_origin;
      default:        prdata = '0;
    endcase
  end

  assign amplitude = amplitude_r;
  assign coef      = coef_r;

endmodule

// File: design/egpa_coord.sv
// ----------------------------------------------------------------------------
// egpa_coord: coordinate pipeline
// Four stages: index clamp and products, affine sums, magnitudes with the
// far-field test, and squares of the magnitudes.
// ----------------------------------------------------------------------------
module egpa_coord
  import egpa_pkg::*;
#(
  parameter int GRID_SIZE = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [IDX_W-1:0] col_index,
  input  logic [IDX_W-1:0] row_index,
  input  coef_t            coef,
  output logic             out_vld,
  output logic [SQ_W-1:0]  sq_u,
  output logic [SQ_W-1:0]  sq_v,
  output logic             far
);

  // Largest index that the grid holds, limited to what the field can carry.
  localparam int IDX_MAX   = (1 << IDX_W) - 1;
  localparam int GRID_LAST = (GRID_SIZE - 1 > IDX_MAX) ? IDX_MAX : GRID_SIZE - 1;
  localparam logic [IDX_W-1:0] GRID_LAST_W = GRID_LAST[IDX_W-1:0];
  localparam int PROD_W = 32 + IDX_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic [IDX_W-1:0]         col_c, row_c;
  logic signed [IDX_W:0]    col_s, row_s;
  logic [COORD_LAT-1:0]     vld_r;
  logic signed [PROD_W-1:0] uc_r, ur_r, vc_r, vr_r;
  logic signed [SUM_W-1:0]  u_r, v_r;
  logic signed [SUM_W-1:0]  u_nxt, v_nxt;
  logic [SUM_W-1:0]         au, av;
  logic [MAG_W-1:0]         au_r, av_r;
  logic                     far_nxt;
  logic                     far3_r, far4_r;
  logic [SQ_W-1:0]          squ_r, sqv_r;

  // Indices past the grid are pinned to its last row or column.
  assign col_c = (col_index > GRID_LAST_W) ? GRID_LAST_W : col_index;
  assign row_c = (row_index > GRID_LAST_W) ? GRID_LAST_W : row_index;
  assign col_s = signed'({1'b0, col_c});
  assign row_s = signed'({1'b0, row_c});

  // Affine sums of the registered products.
  assign u_nxt = SUM_W'(uc_r) + SUM_W'(ur_r) + SUM_W'(coef.u_origin);
  assign v_nxt = SUM_W'(vc_r) + SUM_W'(vr_r) + SUM_W'(coef.v_origin);

  // Magnitudes; anything at or past 8.0 on either axis contributes nothing.
  assign au      = u_r[SUM_W-1] ? SUM_W'(-u_r) : SUM_W'(u_r);
  assign av      = v_r[SUM_W-1] ? SUM_W'(-v_r) : SUM_W'(v_r);
  assign far_nxt = (au[SUM_W-1:MAG_W] != '0) || (av[SUM_W-1:MAG_W] != '0);

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[COORD_LAT-2:0], in_vld};
    end
  end

  // Data stages.
  always_ff @(posedge clk) begin
    uc_r   <= coef.u_col_step * col_s;
    ur_r   <= coef.u_row_step * row_s;
    vc_r   <= coef.v_col_step * col_s;
    vr_r   <= coef.v_row_step * row_s;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    au_r   <= au[MAG_W-1:0];
    av_r   <= av[MAG_W-1:0];
    far3_r <= far_nxt;
    squ_r  <= au_r * au_r;
    sqv_r  <= av_r * av_r;
    far4_r <= far3_r;
  end

  assign out_vld = vld_r[COORD_LAT-1];
  assign sq_u    = squ_r;
  assign sq_v    = sqv_r;
  assign far     = far4_r;

endmodule

// File: design/egpa_exp.sv
// ----------------------------------------------------------------------------
// egpa_exp: exp(-arg) lookup with linear interpolation
// Four stages: argument and table index, table read, slope product, and the
// interpolated value in Q30. The table is built at elaboration.
// ----------------------------------------------------------------------------
module egpa_exp
  import egpa_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [SQ_W-1:0] sq_u,
  input  logic [SQ_W-1:0] sq_v,
  input  logic            far,
  output logic            out_vld,
  output logic [G_W-1:0]  g,
  output logic            zero
);

  localparam int IDXW  = $clog2(EXP_TABLE_DEPTH);
  localparam int FR_W  = 20;
  localparam int P_W   = FR_W + IDXW + 1;
  localparam logic [IDXW:0] DEPTH_W = EXP_TABLE_DEPTH[IDXW:0];
  localparam logic [IDXW-1:0] IDX_LAST = IDXW'(EXP_TABLE_DEPTH - 1);
  localparam int DIFF_W = 31;
  localparam int SLP_W  = DIFF_W + FR_W;

  // exp(-f) in Q32 for f up to one half, by an alternating Taylor series.
  function automatic logic [63:0] exp_frac(input logic [63:0] f);
    logic [63:0]        term;
    logic signed [63:0] acc;
    term = 64'h1_0000_0000;
    acc  = 64'sh1_0000_0000;
    term = ((term * f) >> 32) / 64'd1;  acc = acc - signed'(term);
    term = ((term * f) >> 32) / 64'd2;  acc = acc + signed'(term);
    term = ((term * f) >> 32) / 64'd3;  acc = acc - signed'(term);
    term = ((term * f) >> 32) / 64'd4;  acc = acc + signed'(term);
    term = ((term * f) >> 32) / 64'd5;  acc = acc - signed'(term);
    term = ((term * f) >> 32) / 64'd6;  acc = acc + signed'(term);
    term = ((term * f) >> 32) / 64'd7;  acc = acc - signed'(term);
    term = ((term * f) >> 32) / 64'd8;  acc = acc + signed'(term);
    term = ((term * f) >> 32) / 64'd9;  acc = acc - signed'(term);
    term = ((term * f) >> 32) / 64'd10; acc = acc + signed'(term);
    term = ((term * f) >> 32) / 64'd11; acc = acc - signed'(term);
    term = ((term * f) >> 32) / 64'd12; acc = acc + signed'(term);
    term = ((term * f) >> 32) / 64'd13; acc = acc - signed'(term);
    term = ((term * f) >> 32) / 64'd14; acc = acc + signed'(term);
    term = ((term * f) >> 32) / 64'd15; acc = acc - signed'(term);
    term = ((term * f) >> 32) / 64'd16; acc = acc + signed'(term);
    return (acc < 0) ? 64'd0 : 64'(acc);
  endfunction

  // Table entry k: exp(-16k/depth) in Q30, whole halves applied as powers of h.
  function automatic logic [31:0] exp_entry(input int k);
    logic [63:0] h;
    logic [63:0] x;
    logic [63:0] m;
    logic [63:0] val;
    h   = exp_frac(64'h8000_0000);
    x   = ((64'(k) * 64'd16) << 32) / 64'(EXP_TABLE_DEPTH);
    m   = x >> 31;
    val = exp_frac(x & 64'h7FFF_FFFF);
    for (int i = 0; i < 33; i++) begin
      if (64'(i) < m) begin
        val = (val * h) >> 32;
      end
    end
    return val[33:2];
  endfunction

  // Left and right neighbors of each interpolation interval.
  logic [31:0] rom_lo [EXP_TABLE_DEPTH];
  logic [31:0] rom_hi [EXP_TABLE_DEPTH];

  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [31:0] LO = exp_entry(k);
    localparam logic [31:0] HI = exp_entry(k + 1);
    assign rom_lo[k] = LO;
    assign rom_hi[k] = HI;
  end

  logic [SQ_W:0]      arg_sum;
  logic [21:0]        arg;
  logic [P_W-1:0]     p;
  logic [IDXW-1:0]    idx_nxt;
  logic [EXP_LAT-1:0] vld_r;
  logic [IDXW-1:0]    idx_r;
  logic [FR_W-1:0]    fr5_r, fr6_r;
  logic               zero5_r, zero6_r, zero7_r, zero8_r;
  logic [31:0]        t0_r, t1_r;
  logic               dn_nxt;
  logic [DIFF_W-1:0]  diff_nxt;
  logic               dn7_r;
  logic [G_W-1:0]     t07_r;
  logic [SLP_W-1:0]   slope_r;
  logic [G_W-1:0]     step;
  logic [G_W-1:0]     g_r;

  // Argument (u^2+v^2)/2 in Q16; index and fraction of arg*depth/16.
  assign arg_sum = {1'b0, sq_u} + {1'b0, sq_v};
  assign arg     = arg_sum[SQ_W:17];
  assign p       = P_W'(arg[FR_W-1:0]) * P_W'(DEPTH_W);
  assign idx_nxt = (p[P_W-1:FR_W] > {1'b0, IDX_LAST}) ? IDX_LAST : p[FR_W+IDXW-1:FR_W];

  // Slope of the interval and the direction it runs.
  assign dn_nxt   = (t0_r >= t1_r);
  assign diff_nxt = dn_nxt ? DIFF_W'(t0_r - t1_r) : DIFF_W'(t1_r - t0_r);

  // Interpolated value.
  assign step = slope_r[SLP_W-1:FR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[EXP_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    fr5_r   <= p[FR_W-1:0];
    zero5_r <= far | (arg[21:20] != 2'b00);
    t0_r    <= rom_lo[idx_r];
    t1_r    <= rom_hi[idx_r];
    fr6_r   <= fr5_r;
    zero6_r <= zero5_r;
    dn7_r   <= dn_nxt;
    t07_r   <= t0_r[G_W-1:0];
    slope_r <= diff_nxt * fr6_r;
    zero7_r <= zero6_r;
    g_r     <= dn7_r ? (t07_r - step) : (t07_r + step);
    zero8_r <= zero7_r;
  end

  assign out_vld = vld_r[EXP_LAT-1];
  assign g       = g_r;
  assign zero    = zero8_r;

endmodule

// File: design/elliptical_gaussian_pixel_accumulate.sv
// ----------------------------------------------------------------------------
// elliptical_gaussian_pixel_accumulate: Gaussian component pixel accumulator
// Adds amplitude*exp(-(u^2+v^2)/2) to a pixel brightness, with u and v affine
// in the pixel indices, and saturates the sum to signed Q15.16.
//
//   channel  ports                                        word
//   input    start, busy, in_col_index, in_row_index,     one pixel
//            in_prior_brightness
//   result   out_valid, out_new_brightness, out_saturated one updated pixel
//   config   psel, penable, pwrite, paddr, pwdata,        one register
//            prdata, pready
//
// A pixel is taken in every clock cycle in which start is high and busy is low.
// Ten register stages (four coordinate stages, four exp stages, amplitude
// product and accumulate) lie between an accepted pixel and its result.
// busy is high during reset and for the first cycle after it. Results are
// not held back; out_valid marks each for a single cycle.
// ----------------------------------------------------------------------------
module elliptical_gaussian_pixel_accumulate
  import egpa_pkg::*;
#(
  parameter int GRID_SIZE       = 1024,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [IDX_W-1:0]   in_col_index,
  input  logic [IDX_W-1:0]   in_row_index,
  input  logic signed [31:0] in_prior_brightness,
  output logic               out_valid,
  output logic signed [31:0] out_new_brightness,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PRIOR_LAT = COORD_LAT + EXP_LAT + 1;

  logic               busy_r;
  logic               accept;
  logic signed [31:0] amplitude;
  coef_t              coef;
  logic               c_vld;
  logic [SQ_W-1:0]    sq_u, sq_v;
  logic               far;
  logic               e_vld;
  logic [G_W-1:0]     g;
  logic               zero;
  logic signed [31:0] prior_r [PRIOR_LAT];
  logic               vld9_r, zero9_r;
  logic signed [63:0] prod_r;
  logic signed [33:0] contrib;
  logic signed [33:0] sum;
  logic               out_valid_r;
  logic signed [31:0] out_new_r;
  logic               out_sat_r;
  logic signed [31:0] new_nxt;
  logic               sat_nxt;

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  egpa_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .amplitude (amplitude),
    .coef      (coef)
  );

  egpa_coord #(
    .GRID_SIZE (GRID_SIZE)
  ) u_coord (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (accept),
    .col_index (in_col_index),
    .row_index (in_row_index),
    .coef      (coef),
    .out_vld   (c_vld),
    .sq_u      (sq_u),
    .sq_v      (sq_v),
    .far       (far)
  );

  egpa_exp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (c_vld),
    .sq_u    (sq_u),
    .sq_v    (sq_v),
    .far     (far),
    .out_vld (e_vld),
    .g       (g),
    .zero    (zero)
  );

  // Prior brightness rides alongside the coordinate and exp stages.
  always_ff @(posedge clk) begin
    prior_r[0] <= in_prior_brightness;
    for (int i = 1; i < PRIOR_LAT; i++) begin
      prior_r[i] <= prior_r[i-1];
    end
  end

  // Amplitude times the exp value, Q16 times Q30.
  always_ff @(posedge clk) begin
    prod_r  <= amplitude * signed'({1'b0, g});
    zero9_r <= zero;
  end

  // Floor back to Q16, accumulate and clip.
  assign contrib = zero9_r ? 34'sd0 : prod_r[63:30];
  assign sum     = 34'(prior_r[PRIOR_LAT-1]) + contrib;

  always_comb begin
    if (sum > 34'sh0_7FFF_FFFF) begin
      new_nxt = 32'sh7FFF_FFFF;
      sat_nxt = 1'b1;
    end else if (sum < -34'sh0_8000_0000) begin
      new_nxt = 32'sh8000_0000;
      sat_nxt = 1'b1;
    end else begin
      new_nxt = sum[31:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld9_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld9_r      <= e_vld;
      out_valid_r <= vld9_r;
    end
  end

  always_ff @(posedge clk) begin
    out_new_r <= new_nxt;
    out_sat_r <= sat_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_new_brightness = out_new_r;
  assign out_saturated      = out_sat_r;

endmodule
